// ===== hdl/dafmt_pkg.sv =====
`timescale 1ns / 1ps

package dafmt_pkg;

   localparam int IN_DATA_W      = 88;
   localparam int IN_USER_W      = 1;
   localparam int OUT_DATA_W     = 8;
   localparam int VALUE_W        = 32;
   localparam int FIXED_W        = 48;
   localparam int FD_W           = 4;
   localparam int DIGIT_W        = 4;
   localparam int CNT_W          = 4;
   localparam int MAX_INT_DIGITS = 10;
   localparam int PROD_W         = 64;
   localparam int RECIP_SHIFT    = 35;
   localparam int QUOT_W         = PROD_W - RECIP_SHIFT;

   localparam logic [VALUE_W-1:0]    RECIP_TEN   = 32'hCCCC_CCCD;
   localparam logic [OUT_DATA_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [OUT_DATA_W-1:0] ASCII_MINUS = 8'd45;
   localparam logic [OUT_DATA_W-1:0] ASCII_POINT = 8'd46;

   localparam logic KIND_INT   = 1'b0;
   localparam logic KIND_FIXED = 1'b1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DIGIT = 6'b000010,
      S_SIGN  = 6'b000100,
      S_INT   = 6'b001000,
      S_POINT = 6'b010000,
      S_FRAC  = 6'b100000
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

// ===== hdl/dafmt_div10.sv =====
`timescale 1ns / 1ps

// Divides by ten through a registered multiply by the scaled reciprocal.
// Quotient and remainder appear in the cycle after the operand is presented.
module dafmt_div10 (
   input  logic                            clock,
   input  logic [dafmt_pkg::VALUE_W-1:0]   x,
   output logic [dafmt_pkg::QUOT_W-1:0]    q,
   output logic [dafmt_pkg::DIGIT_W-1:0]   r
);

   logic [dafmt_pkg::PROD_W-1:0]  prod_ff;
   logic [dafmt_pkg::PROD_W-1:0]  prod_in;
   logic [dafmt_pkg::VALUE_W-1:0] x_ff;
   logic [dafmt_pkg::VALUE_W-1:0] ten_q;
   logic [dafmt_pkg::VALUE_W-1:0] diff;

   assign prod_in = {32'd0, x} * {32'd0, dafmt_pkg::RECIP_TEN};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff    <= x;
   end

   assign q     = prod_ff[dafmt_pkg::PROD_W-1:dafmt_pkg::RECIP_SHIFT];
   assign ten_q = {q, 3'b000} + {2'b00, q, 1'b0};
   assign diff  = x_ff - ten_q;
   assign r     = diff[dafmt_pkg::DIGIT_W-1:0];

endmodule

// ===== hdl/dafmt_digits.sv =====
`timescale 1ns / 1ps

// Digit stack: remainders are pushed least significant first and popped
// most significant first.
module dafmt_digits (
   input  logic                            clock,
   input  logic                            reset,
   input  dafmt_pkg::stack_ctl_type        ctl,
   input  logic [dafmt_pkg::DIGIT_W-1:0]   digit,
   output logic [dafmt_pkg::DIGIT_W-1:0]   top,
   output logic [dafmt_pkg::CNT_W-1:0]     count
);

   localparam int STACK_W = dafmt_pkg::DIGIT_W * dafmt_pkg::MAX_INT_DIGITS;

   logic [STACK_W-1:0]              stack_ff;
   logic [STACK_W-1:0]              stack_in;
   logic [dafmt_pkg::CNT_W-1:0]     count_ff;
   logic [dafmt_pkg::CNT_W-1:0]     count_in;

   always_comb begin
      stack_in = stack_ff;
      count_in = count_ff;
      if (ctl.push) begin
         stack_in = {stack_ff[STACK_W-dafmt_pkg::DIGIT_W-1:0], digit};
         count_in = count_ff + 4'd1;
      end else if (ctl.pop) begin
         stack_in = stack_ff >> dafmt_pkg::DIGIT_W;
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      stack_ff <= stack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top   = stack_ff[dafmt_pkg::DIGIT_W-1:0];
   assign count = count_ff;

endmodule

// ===== hdl/decimal_ascii_formatter.sv =====
`timescale 1ns / 1ps
// The integer part is split into decimal digits, one divide-by-ten step per cycle through the
// shared reciprocal multiplier; then each character is emitted in order, waiting while the
// output is stalled. A new input beat is accepted only in idle, once the last character of the
// previous item has been loaded into the output register. The first character, a minus sign or
// the leading digit, follows once every integer digit is on the stack.
// Synchronous reset returns the sequencer to idle and empties the digit stack and output.
module decimal_ascii_formatter #(
   parameter int FRAC_BITS       = 16,
   parameter int MAX_FRAC_DIGITS = 9
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // int_value [31:0], fixed_value [79:32], frac_digits [83:80], zero fill [87:84].
   input  logic [dafmt_pkg::IN_DATA_W-1:0]       req_tdata,
   // kind [0].
   input  logic [dafmt_pkg::IN_USER_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // character [7:0].
   output logic [dafmt_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int PROD_F_W = FRAC_BITS + 4;

   dafmt_pkg::state_type             state_ff;
   dafmt_pkg::state_type             state_in;
   logic                             kind_ff;
   logic                             kind_in;
   logic                             neg_ff;
   logic                             neg_in;
   logic [dafmt_pkg::FD_W-1:0]       nd_ff;
   logic [dafmt_pkg::FD_W-1:0]       nd_in;
   logic [FRAC_BITS-1:0]             frac_ff;
   logic [FRAC_BITS-1:0]             frac_in;
   logic                             out_valid_ff;
   logic                             out_valid_in;
   logic [dafmt_pkg::OUT_DATA_W-1:0] out_char_ff;
   logic [dafmt_pkg::OUT_DATA_W-1:0] out_char_in;
   logic                             out_last_ff;
   logic                             out_last_in;

   logic [dafmt_pkg::VALUE_W-1:0]    in_int;
   logic [dafmt_pkg::FIXED_W-1:0]    in_fixed;
   logic [dafmt_pkg::FD_W-1:0]       in_fd;
   logic [dafmt_pkg::FIXED_W-1:0]    fixed_shift;
   logic [dafmt_pkg::VALUE_W-1:0]    mag_sel;
   logic [dafmt_pkg::VALUE_W-1:0]    div_x;
   logic [dafmt_pkg::QUOT_W-1:0]     div_q;
   logic [dafmt_pkg::DIGIT_W-1:0]    div_r;
   logic [PROD_F_W-1:0]              frac_ten;
   logic [dafmt_pkg::DIGIT_W-1:0]    stack_top;
   logic [dafmt_pkg::CNT_W-1:0]      dig_count;
   dafmt_pkg::stack_ctl_type         stk_ctl;
   logic                             emit_ok;
   logic                             emit;
   logic [dafmt_pkg::OUT_DATA_W-1:0] emit_char;
   logic                             emit_last;

   assign in_int      = req_tdata[31:0];
   assign in_fixed    = req_tdata[79:32];
   assign in_fd       = req_tdata[83:80];
   assign fixed_shift = in_fixed >> FRAC_BITS;

   always_comb begin
      if (req_tuser[0] == dafmt_pkg::KIND_FIXED) begin
         mag_sel = fixed_shift[dafmt_pkg::VALUE_W-1:0];
      end else if (in_int[dafmt_pkg::VALUE_W-1]) begin
         mag_sel = 32'd0 - in_int;
      end else begin
         mag_sel = in_int;
      end
   end

   assign frac_ten = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);
   assign emit_ok  = !out_valid_ff || rsp_tready;

   dafmt_div10 u_div10 (
      .clock (clock),
      .x     (div_x),
      .q     (div_q),
      .r     (div_r)
   );

   dafmt_digits u_digits (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .digit (div_r),
      .top   (stack_top),
      .count (dig_count)
   );

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      neg_in    = neg_ff;
      nd_in     = nd_ff;
      frac_in   = frac_ff;
      div_x     = {3'b000, div_q};
      stk_ctl   = '0;
      emit      = 1'b0;
      emit_char = dafmt_pkg::ASCII_ZERO;
      emit_last = 1'b0;
      case (state_ff)
         dafmt_pkg::S_IDLE: begin
            div_x = mag_sel;
            if (req_tvalid) begin
               kind_in  = req_tuser[0];
               neg_in   = (req_tuser[0] == dafmt_pkg::KIND_INT) && in_int[dafmt_pkg::VALUE_W-1];
               nd_in    = (in_fd > 4'(MAX_FRAC_DIGITS)) ? 4'(MAX_FRAC_DIGITS) : in_fd;
               frac_in  = in_fixed[FRAC_BITS-1:0];
               state_in = dafmt_pkg::S_DIGIT;
            end
         end
         dafmt_pkg::S_DIGIT: begin
            stk_ctl.push = 1'b1;
            if (div_q != '0) begin
               state_in = dafmt_pkg::S_DIGIT;
            end else if (neg_ff) begin
               state_in = dafmt_pkg::S_SIGN;
            end else begin
               state_in = dafmt_pkg::S_INT;
            end
         end
         dafmt_pkg::S_SIGN: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_char = dafmt_pkg::ASCII_MINUS;
               state_in  = dafmt_pkg::S_INT;
            end
         end
         dafmt_pkg::S_INT: begin
            if (emit_ok) begin
               emit        = 1'b1;
               stk_ctl.pop = 1'b1;
               emit_char   = dafmt_pkg::ASCII_ZERO + {4'd0, stack_top};
               emit_last   = (dig_count == 4'd1) && (kind_ff == dafmt_pkg::KIND_INT);
               if (dig_count == 4'd1) begin
                  state_in = (kind_ff == dafmt_pkg::KIND_FIXED) ? dafmt_pkg::S_POINT
                                                                : dafmt_pkg::S_IDLE;
               end
            end
         end
         dafmt_pkg::S_POINT: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_char = dafmt_pkg::ASCII_POINT;
               emit_last = (nd_ff == '0);
               state_in  = (nd_ff == '0) ? dafmt_pkg::S_IDLE : dafmt_pkg::S_FRAC;
            end
         end
         dafmt_pkg::S_FRAC: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_char = dafmt_pkg::ASCII_ZERO + {4'd0, frac_ten[PROD_F_W-1:FRAC_BITS]};
               emit_last = (nd_ff == 4'd1);
               frac_in   = frac_ten[FRAC_BITS-1:0];
               nd_in     = nd_ff - 4'd1;
               state_in  = (nd_ff == 4'd1) ? dafmt_pkg::S_IDLE : dafmt_pkg::S_FRAC;
            end
         end
         default: begin
            state_in = dafmt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = emit_char;
         out_last_in  = emit_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dafmt_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      neg_ff      <= neg_in;
      nd_ff       <= nd_in;
      frac_ff     <= frac_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == dafmt_pkg::S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   a_idle_stack_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dafmt_pkg::S_IDLE) |-> (dig_count == '0))
      else $error("digit stack not empty in idle");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      dig_count <= 4'(dafmt_pkg::MAX_INT_DIGITS))
      else $error("digit stack overflow");

   a_frac_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dafmt_pkg::S_FRAC) |-> (nd_ff != '0))
      else $error("fraction digit count exhausted in fraction state");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >= dafmt_pkg::ASCII_ZERO && rsp_tdata <= 8'd57) ||
                      rsp_tdata == dafmt_pkg::ASCII_MINUS ||
                      rsp_tdata == dafmt_pkg::ASCII_POINT))
      else $error("output character outside digit, minus and point");

endmodule

// ===== dv/decimal_ascii_formatter_tb.sv =====
`timescale 1ns / 1ps

module decimal_ascii_formatter_tb;

   localparam int FRAC_BITS       = 16;
   localparam int MAX_FRAC_DIGITS = 9;
   localparam int RANDOM_ITEMS    = 200;

   typedef struct packed {
      logic [dafmt_pkg::OUT_DATA_W-1:0] ch;
      logic                             last;
   } char_beat_type;

   typedef struct {
      logic                          kind;
      logic [dafmt_pkg::VALUE_W-1:0] int_value;
      logic [dafmt_pkg::FIXED_W-1:0] fixed_value;
      logic [dafmt_pkg::FD_W-1:0]    frac_digits;
      string                         golden;
   } number_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [dafmt_pkg::IN_DATA_W-1:0]  req_tdata = '0;
   logic [dafmt_pkg::IN_USER_W-1:0]  req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [dafmt_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;

   char_beat_type  expected_chars[$];
   number_row_type directed_rows[$];
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             mismatches = 0;

   decimal_ascii_formatter #(
      .FRAC_BITS       (FRAC_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[decimal_ascii_formatter] ERROR");
      $finish;
   end

   function automatic void push_char(input logic [dafmt_pkg::OUT_DATA_W-1:0] ch);
      char_beat_type beat;
      beat.ch = ch;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
   endfunction

   function automatic void push_decimal(input logic [dafmt_pkg::VALUE_W-1:0] mag);
      logic [dafmt_pkg::DIGIT_W-1:0] digits[dafmt_pkg::MAX_INT_DIGITS];
      logic [dafmt_pkg::VALUE_W-1:0] rest;
      logic [dafmt_pkg::VALUE_W-1:0] rem;
      int                            count;
      rest = mag;
      count = 0;
      do begin
         rem = rest % 32'd10;
         digits[count] = rem[dafmt_pkg::DIGIT_W-1:0];
         rest = rest / 32'd10;
         count++;
      end while (rest != 0 && count < dafmt_pkg::MAX_INT_DIGITS);
      while (count > 0) begin
         count--;
         push_char(dafmt_pkg::ASCII_ZERO + {4'd0, digits[count]});
      end
   endfunction

   function automatic void predict_chars(input logic kind,
                                         input logic [dafmt_pkg::VALUE_W-1:0] ival,
                                         input logic [dafmt_pkg::FIXED_W-1:0] fval,
                                         input logic [dafmt_pkg::FD_W-1:0] fd);
      logic [dafmt_pkg::VALUE_W-1:0] mag;
      logic [FRAC_BITS-1:0]          frac;
      logic [FRAC_BITS+3:0]          prod;
      int                            ndigits;
      if (kind == dafmt_pkg::KIND_INT) begin
         mag = ival;
         if (ival[dafmt_pkg::VALUE_W-1]) begin
            push_char(dafmt_pkg::ASCII_MINUS);
            mag = -ival;
         end
         push_decimal(mag);
      end else begin
         push_decimal(fval[FRAC_BITS +: dafmt_pkg::VALUE_W]);
         push_char(dafmt_pkg::ASCII_POINT);
         ndigits = (fd > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(fd);
         frac = fval[FRAC_BITS-1:0];
         for (int k = 0; k < ndigits; k++) begin
            prod = ({4'b0000, frac} << 3) + ({4'b0000, frac} << 1);
            push_char(dafmt_pkg::ASCII_ZERO + {4'd0, prod[FRAC_BITS +: 4]});
            frac = prod[FRAC_BITS-1:0];
         end
      end
      expected_chars[expected_chars.size()-1].last = 1'b1;
   endfunction

   function automatic void push_golden(input string text);
      char_beat_type beat;
      for (int i = 0; i < text.len(); i++) begin
         beat.ch = text[i];
         beat.last = (i == text.len() - 1);
         expected_chars.push_back(beat);
      end
   endfunction

   function automatic void add_row(input logic kind, input logic [dafmt_pkg::VALUE_W-1:0] ival,
                                   input logic [dafmt_pkg::FIXED_W-1:0] fval,
                                   input logic [dafmt_pkg::FD_W-1:0] fd,
                                   input string golden);
      number_row_type row;
      row.kind = kind;
      row.int_value = ival;
      row.fixed_value = fval;
      row.frac_digits = fd;
      row.golden = golden;
      directed_rows.push_back(row);
   endfunction

   task automatic send_number(input number_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, row.frac_digits, row.fixed_value, row.int_value};
      req_tuser  <= row.kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (row.golden != "") begin
         push_golden(row.golden);
      end else begin
         predict_chars(row.kind, row.int_value, row.fixed_value, row.frac_digits);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual char %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            if (rsp_tdata !== expected_chars[0].ch || rsp_tlast !== expected_chars[0].last) begin
               $display("%0t: mismatch, expected char %h last %b, actual char %h last %b",
                        $time, expected_chars[0].ch, expected_chars[0].last,
                        rsp_tdata, rsp_tlast);
               mismatches++;
            end
            void'(expected_chars.pop_front());
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      number_row_type row;
      int             phase_idle[4];
      int             phase_stall[4];
      phase_idle  = '{0, 46, 0, 10};
      phase_stall = '{0, 0, 46, 10};

      add_row(dafmt_pkg::KIND_INT, 32'd0, 48'h0, 4'd0, "0");
      add_row(dafmt_pkg::KIND_INT, 32'd1, 48'h0, 4'd0, "1");
      add_row(dafmt_pkg::KIND_INT, 32'hFFFF_FFFF, 48'h0, 4'd0, "-1");
      add_row(dafmt_pkg::KIND_INT, 32'h7FFF_FFFF, 48'h0, 4'd0, "2147483647");
      add_row(dafmt_pkg::KIND_INT, 32'h8000_0000, 48'h0, 4'd0, "-2147483648");
      add_row(dafmt_pkg::KIND_INT, 32'd1000000000, 48'h0, 4'd0, "1000000000");
      add_row(dafmt_pkg::KIND_INT, 32'd10, 48'h0, 4'd0, "10");
      add_row(dafmt_pkg::KIND_INT, -32'sd10, 48'h0, 4'd0, "-10");
      add_row(dafmt_pkg::KIND_INT, -32'sd123456789, 48'h0, 4'd0, "");
      add_row(dafmt_pkg::KIND_INT, 32'd42, 48'hFFFF_FFFF_FFFF, 4'hF, "42");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h0, 4'd0, "0.");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h0, 4'd3, "0.000");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h0001_8000, 4'd1, "1.5");
      add_row(dafmt_pkg::KIND_FIXED, 32'hFFFF_FFFF, 48'h0002_8000, 4'd10, "");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h000A_0000, 4'd2, "10.00");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h3B9A_CA00_0000, 4'd4, "1000000000.0000");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h8000_0000_0000, 4'd0, "2147483648.");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'hFFFF_FFFF_0000, 4'd0, "4294967295.");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'hFFFF_FFFF_FFFF, 4'd9, "");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h0000_0000_0001, 4'd9, "");
      add_row(dafmt_pkg::KIND_FIXED, 32'h0, 48'h0000_0000_0001, 4'hF, "");
      add_row(dafmt_pkg::KIND_FIXED, 32'h1234_5678, 48'h0000_0000_FFFF, 4'd5, "");

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_number(directed_rows[i]);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            row.kind = 1'($urandom_range(1));
            row.int_value = $urandom >> $urandom_range(31);
            if ($urandom_range(1) == 1) row.int_value = -row.int_value;
            if ($urandom_range(15) == 0) begin
               case ($urandom_range(3))
                  0: row.int_value = 32'h8000_0000;
                  1: row.int_value = 32'h7FFF_FFFF;
                  2: row.int_value = 32'h0;
                  default: row.int_value = 32'hFFFF_FFFF;
               endcase
            end
            row.fixed_value[FRAC_BITS-1:0] = FRAC_BITS'($urandom);
            row.fixed_value[FRAC_BITS +: dafmt_pkg::VALUE_W] = $urandom >> $urandom_range(32);
            row.frac_digits = 4'($urandom_range(15));
            row.golden = "";
            send_number(row);
         end
      end
      req_tvalid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("[decimal_ascii_formatter] OK");
      end else begin
         $display("[decimal_ascii_formatter] ERROR");
      end
      $finish;
   end

endmodule

// ===== decimal_ascii_formatter.f =====
hdl/dafmt_pkg.sv
hdl/dafmt_div10.sv
hdl/dafmt_digits.sv
hdl/decimal_ascii_formatter.sv
dv/decimal_ascii_formatter_tb.sv
